[sv/wbtw_pkg.sv]
package wbtw_pkg;

    // Word store geometry
    localparam int WORD_DEPTH = 32;
    localparam int WL_W       = $clog2(WORD_DEPTH + 1);
    localparam int ADDR_W     = $clog2(WORD_DEPTH);

    // Field and counter widths
    localparam int CHAR_W = 8;
    localparam int MAXL_W = 6;
    localparam int CAP_W  = 16;
    localparam int LINE_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CHAR_W-1:0]    t_char;

    localparam t_cfg_idx CFG_MAX_LINE = 1'd0;
    localparam t_cfg_idx CFG_OUT_CAP  = 1'd1;

    localparam logic [MAXL_W-1:0] MAXL_RESET = 6'd20;
    localparam logic [CAP_W-1:0]  CAP_RESET  = 16'd256;

    // Character codes
    localparam t_char CH_END = 8'h00;
    localparam t_char CH_LF  = 8'h0A;
    localparam t_char CH_CR  = 8'h0D;
    localparam t_char CH_SP  = 8'h20;

endpackage

[sv/wbtw_if.sv]
interface wbtw_in_if;
    logic                  valid;
    logic                  ready;
    logic [wbtw_pkg::CHAR_W-1:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

interface wbtw_out_if;
    logic                  valid;
    logic                  ready;
    logic [wbtw_pkg::CHAR_W-1:0] out_char;
    logic                  last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

[sv/wbtw_ram.sv]
module wbtw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/word_boundary_text_wrapper.sv]
// Channel   Dir  Payload                      Transfer
// i_in      in   in_char[7:0]                 valid && ready
// o_out     out  out_char[7:0], last_of_run   valid && ready
// i_cfg_*   in   idx[0], wdata[15:0]          i_cfg_we
//
// A buffered word character or a dropped space is taken in S_IDLE alone. Other
// items run accept, CR LF when wrapping, a read start and n reads for a buffered
// word of n, the trailing character and one finish; a lone delimiter or streamed
// character runs accept, the trailing character and finish; a filled store has no trailer.
// Reset (synchronous, active low) clears the line state and loads register
// defaults; the word store needs no clearing. A stalled output holds the
// sequencer; the input is taken only between items.
module word_boundary_text_wrapper (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wbtw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wbtw_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    wbtw_in_if.sink                           i_in,
    wbtw_out_if.source                        o_out
);

    import wbtw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CR, S_LF, S_RA, S_RD, S_TAIL, S_FIN
    } t_state;

    typedef enum logic [2:0] {
        TR_NONE, TR_END, TR_CR, TR_LF, TR_SP, TR_CHAR
    } t_trail;

    // Saturating line length add
    function automatic logic [LINE_W-1:0] sat_add(logic [LINE_W-1:0] a,
                                                  logic [WL_W-1:0] n);
        logic [LINE_W:0] s;
        s = {1'b0, a} + {{(LINE_W + 1 - WL_W){1'b0}}, n};
        return s[LINE_W] ? {LINE_W{1'b1}} : s[LINE_W-1:0];
    endfunction

    t_state              r_state;
    t_trail              r_trail;
    logic [MAXL_W-1:0]   r_max;
    logic [CAP_W-1:0]    r_cap;
    logic [LINE_W-1:0]   r_line;
    logic [CAP_W-1:0]    r_emit;
    logic [WL_W-1:0]     r_wl;
    logic                r_isr;
    logic                r_pass;
    logic [WL_W-1:0]     r_w;
    t_char               r_ch;
    logic [ADDR_W-1:0]   r_idx;
    logic                r_pv;
    t_char               r_pch;
    logic                r_ov;
    t_char               r_och;
    logic                r_olast;

    t_char               ram_rdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic                ram_we;

    // Handshake helpers
    logic out_free, push_ok, emit_ok, accept;
    assign out_free = !r_ov || o_out.ready;
    assign push_ok  = !r_pv || out_free;
    assign emit_ok  = ({1'b0, r_emit} + 17'd1) < {1'b0, r_cap};
    assign accept   = i_in.valid && (r_state == S_IDLE);

    // Decode the accepted character
    t_char            c;
    logic             is_end, is_cr, is_lf, is_sp, is_word;
    logic             had_store, had, fill;
    logic             d_start, d_wrap_en, d_wrap;
    logic [WL_W-1:0]  d_w;
    t_trail           d_trail;
    logic [LINE_W:0]  line_sum;

    assign c       = i_in.in_char;
    assign is_end  = (c == CH_END);
    assign is_cr   = (c == CH_CR);
    assign is_lf   = (c == CH_LF);
    assign is_sp   = (c == CH_SP);
    assign is_word = !(is_end || is_cr || is_lf || is_sp);
    assign had_store = !r_pass && (r_wl != '0);
    assign had       = r_pass || had_store;
    assign fill      = ((r_wl + 1'b1) == WL_W'(WORD_DEPTH));

    always_comb begin
        d_start   = 1'b1;
        d_wrap_en = had_store;
        d_w       = had_store ? r_wl : '0;
        d_trail   = TR_NONE;
        if (is_end) begin
            d_trail = TR_END;
        end else if (is_cr) begin
            d_trail = TR_CR;
        end else if (is_lf) begin
            d_trail = TR_LF;
        end else if (is_sp) begin
            d_trail = TR_SP;
            if (!had) begin
                d_wrap_en = !r_isr;
                d_start   = r_isr || (r_line != '0);
            end
        end else if (r_pass) begin
            d_trail   = TR_CHAR;
            d_wrap_en = 1'b0;
            d_w       = '0;
        end else begin
            d_wrap_en = 1'b1;
            d_w       = WL_W'(WORD_DEPTH);
            d_start   = fill;
        end
    end

    assign line_sum = {1'b0, r_line} + {{(LINE_W + 1 - WL_W){1'b0}}, d_w};
    assign d_wrap   = d_wrap_en && (r_line != '0)
                   && (line_sum > {{(LINE_W + 1 - MAXL_W){1'b0}}, r_max})
                   && (({1'b0, r_emit} + 17'd3) < {1'b0, r_cap});

    // Per-state result generation and progress
    logic  gen, step, rd_last;
    t_char gen_char;

    assign rd_last = (({1'b0, r_idx} + 1'b1) == r_w);

    always_comb begin
        gen       = 1'b0;
        gen_char  = CH_END;
        step      = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_idx + 1'b1;
        case (r_state)
            S_CR: begin
                gen = 1'b1; gen_char = CH_CR; step = push_ok;
            end
            S_LF: begin
                gen = 1'b1; gen_char = CH_LF; step = push_ok;
            end
            S_RA: begin
                ram_re = 1'b1; ram_raddr = '0; step = 1'b1;
            end
            S_RD: begin
                gen      = emit_ok;
                gen_char = ram_rdata;
                step     = !emit_ok || push_ok;
                ram_re   = step && !rd_last;
            end
            S_TAIL: begin
                case (r_trail)
                    TR_END:  begin gen = 1'b1;    gen_char = CH_END; end
                    TR_CR:   begin gen = emit_ok; gen_char = CH_CR;  end
                    TR_LF:   begin gen = emit_ok; gen_char = CH_LF;  end
                    TR_SP:   begin gen = emit_ok; gen_char = CH_SP;  end
                    TR_CHAR: begin gen = emit_ok; gen_char = r_ch;   end
                    default: begin gen = 1'b0;    gen_char = CH_END; end
                endcase
                step = !gen || push_ok;
            end
            S_FIN: begin
                step = !r_pv || out_free;
            end
            default: begin
                step = 1'b0;
            end
        endcase
    end

    assign ram_we = accept && is_word && !r_pass;

    wbtw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (WORD_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wl[ADDR_W-1:0]),
        .i_wdata (c),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic do_gen, do_fin;
    assign do_gen = gen && step;
    assign do_fin = (r_state == S_FIN) && step;

    // Sequencer, line state and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_max   <= MAXL_RESET;
            r_cap   <= CAP_RESET;
            r_line  <= '0;
            r_emit  <= '0;
            r_wl    <= '0;
            r_isr   <= 1'b0;
            r_pass  <= 1'b0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            // Configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_LINE: r_max <= i_cfg_wdata[MAXL_W-1:0];
                    CFG_OUT_CAP:  r_cap <= i_cfg_wdata[CAP_W-1:0];
                    default: ;
                endcase
            end

            // Move the held item to the output, or drain it
            if (do_gen && r_pv) begin
                r_ov    <= 1'b1;
                r_och   <= r_pch;
                r_olast <= 1'b0;
            end else if (do_fin && r_pv) begin
                r_ov    <= 1'b1;
                r_och   <= r_pch;
                r_olast <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end

            // Hold the newest item until the next one shows whether it is last;
            // the terminator restarts the count for the next text
            if (do_gen) begin
                r_pv   <= 1'b1;
                r_pch  <= gen_char;
                r_emit <= (r_state == S_TAIL && r_trail == TR_END) ? '0
                                                                   : r_emit + 1'b1;
            end else if (do_fin) begin
                r_pv <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_w     <= d_w;
                        r_trail <= d_trail;
                        r_ch    <= c;
                        if (is_word) begin
                            r_isr <= 1'b0;
                            if (!r_pass) begin
                                r_wl   <= fill ? '0 : r_wl + 1'b1;
                                r_pass <= fill;
                            end
                        end else begin
                            r_wl   <= '0;
                            r_pass <= 1'b0;
                            r_isr  <= is_sp && d_start;
                        end
                        if (!d_start) begin
                            r_state <= S_IDLE;
                        end else if (d_wrap) begin
                            r_state <= S_CR;
                        end else if (d_w != '0) begin
                            r_state <= S_RA;
                        end else begin
                            r_state <= S_TAIL;
                        end
                    end
                end
                S_CR: begin
                    if (step) begin
                        r_line  <= '0;
                        r_state <= S_LF;
                    end
                end
                S_LF: begin
                    if (step) begin
                        r_state <= (r_w != '0) ? S_RA : S_TAIL;
                    end
                end
                S_RA: begin
                    r_idx   <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    if (step) begin
                        if (rd_last) begin
                            r_line  <= sat_add(r_line, r_w);
                            r_state <= (r_trail == TR_NONE) ? S_FIN : S_TAIL;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_TAIL: begin
                    if (step) begin
                        case (r_trail)
                            TR_END: begin
                                r_line <= '0;
                                r_wl   <= '0;
                                r_isr  <= 1'b0;
                                r_pass <= 1'b0;
                            end
                            TR_LF:   r_line <= '0;
                            TR_SP:   r_line <= sat_add(r_line, WL_W'(1));
                            TR_CHAR: r_line <= sat_add(r_line, WL_W'(1));
                            default: ;
                        endcase
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (step) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_ov;
    assign o_out.out_char    = r_och;
    assign o_out.last_of_run = r_olast;

endmodule

[bench/word_boundary_text_wrapper_test.sv]
module word_boundary_text_wrapper_test;
    import wbtw_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RANDOM_ITEMS  = 150;
    // Leave margin for the longest item to finish
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_LIMIT   = 50000;
    // Allow the slowest correct run a wide margin
    localparam int LIMIT_CYCLES  = 200000;
    localparam int MAX_REPORTS   = 100;
    localparam int unsigned LINE_SAT = 32'h0000_FFFF;

    typedef struct {
        t_char ch;
        logic  last;
    } wrap_out_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    wbtw_in_if  in_ch ();
    wbtw_out_if out_ch ();

    word_boundary_text_wrapper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Wrapping predictor state
    int unsigned max_line;
    int unsigned out_cap;
    int unsigned line_len;
    int unsigned emitted;
    int unsigned word_len;
    t_char       word_buf [WORD_DEPTH];
    bit          in_spaces;
    bit          streaming;
    t_char       step_chars [$];
    wrap_out_t   wrapped_text_q [$];

    // Shared stimulus controls
    int unsigned items_sent;
    int          mismatch_count;
    int          rx_hold_left;
    bit          rx_steady;
    bit          tx_steady;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Predictor
    function automatic void put_char(t_char c);
        step_chars.push_back(c);
    endfunction

    function automatic void emit_bounded(t_char c);
        if (emitted + 1 < out_cap) begin
            put_char(c);
            emitted++;
        end
    endfunction

    function automatic void grow_line(int unsigned n);
        line_len = (line_len + n > LINE_SAT) ? LINE_SAT : line_len + n;
    endfunction

    function automatic void maybe_wrap(int unsigned wl);
        if (line_len > 0 && line_len + wl > max_line && emitted + 3 < out_cap) begin
            put_char(CH_CR);
            put_char(CH_LF);
            emitted += 2;
            line_len = 0;
        end
    endfunction

    function automatic void place_word(int unsigned wl);
        maybe_wrap(wl);
        for (int j = 0; j < wl && j < WORD_DEPTH; j++)
            emit_bounded(word_buf[j]);
        grow_line(wl);
    endfunction

    function automatic bit flush_pending_word();
        bit had;
        had = 1'b0;
        if (streaming) begin
            streaming = 1'b0;
            had = 1'b1;
        end else if (word_len > 0) begin
            place_word(word_len);
            had = 1'b1;
        end
        word_len = 0;
        return had;
    endfunction

    function automatic void clear_text_state();
        line_len  = 0;
        emitted   = 0;
        word_len  = 0;
        in_spaces = 1'b0;
        streaming = 1'b0;
    endfunction

    function automatic void predict_wrapped_output(t_char c);
        wrap_out_t r;
        bit        had;
        step_chars.delete();
        if (c == CH_END) begin
            had = flush_pending_word();
            put_char(CH_END);
            clear_text_state();
        end else if (c == CH_CR) begin
            had = flush_pending_word();
            emit_bounded(CH_CR);
            in_spaces = 1'b0;
        end else if (c == CH_LF) begin
            had = flush_pending_word();
            emit_bounded(CH_LF);
            line_len  = 0;
            in_spaces = 1'b0;
        end else if (c == CH_SP) begin
            had = flush_pending_word();
            if (had || in_spaces) begin
                emit_bounded(CH_SP);
                grow_line(1);
                in_spaces = 1'b1;
            end else if (line_len > 0) begin
                // space after CR acts as an empty word
                maybe_wrap(0);
                emit_bounded(CH_SP);
                grow_line(1);
                in_spaces = 1'b1;
            end
        end else begin
            in_spaces = 1'b0;
            if (streaming) begin
                emit_bounded(c);
                grow_line(1);
            end else begin
                if (word_len < WORD_DEPTH)
                    word_buf[word_len] = c;
                word_len++;
                // full store: decide now, then stream the rest of the word
                if (word_len >= WORD_DEPTH) begin
                    place_word(WORD_DEPTH);
                    word_len  = 0;
                    streaming = 1'b1;
                end
            end
        end
        foreach (step_chars[k]) begin
            r.ch   = step_chars[k];
            r.last = (k == step_chars.size() - 1);
            wrapped_text_q.push_back(r);
        end
    endfunction

    // Reporting
    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Register write, applied to the predictor at the write edge
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        if (idx == CFG_MAX_LINE)
            max_line = data[MAXL_W-1:0];
        else
            out_cap = data[CAP_W-1:0];
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Send one item; valid stays high afterwards until a gap or release
    task automatic send_char(input t_char c);
        if (!tx_steady) begin
            while ($urandom_range(99) < 35) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_char <= c;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predict_wrapped_output(c);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(t_char'(s[i]));
    endtask

    task automatic send_word(input int unsigned len);
        t_char c;
        for (int i = 0; i < len; i++) begin
            do c = t_char'($urandom_range(1, 255));
            while (c == CH_CR || c == CH_LF || c == CH_SP);
            send_char(c);
        end
    endtask

    // Drop valid, wait for every expected item, then let the block settle
    task automatic wait_block_idle();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (wrapped_text_q.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: random stalls, steady stretches and long hold-offs
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                out_ch.ready <= 1'b0;
                rx_hold_left--;
            end else if (rx_steady) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= 35);
            end
        end
    end

    // Compare each accepted item with the oldest expectation
    initial begin
        t_char     got_ch;
        logic      got_last;
        wrap_out_t want;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got_ch   = out_ch.out_char;
                got_last = out_ch.last_of_run;
                // let the sender record what it accepted at this edge
                #1;
                if (wrapped_text_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item out_char=%02h", got_ch));
                end else begin
                    want = wrapped_text_q.pop_front();
                    if (got_ch !== want.ch)
                        report_mismatch($sformatf("out_char got %02h want %02h",
                                                  got_ch, want.ch));
                    if (got_last !== want.last)
                        report_mismatch($sformatf("last_of_run got %b want %b (char %02h)",
                                                  got_last, want.last, want.ch));
                end
            end
        end
    end

    // Reset defaults apply before any write
    task automatic test_reset_defaults();
        send_text("  one two");
        send_char(CH_LF);
        send_char(CH_END);
    endtask

    // Wraps, leading and trailing spaces, CR, space after CR, LF
    task automatic test_wrap_and_spaces();
        wait_block_idle();
        write_reg(CFG_MAX_LINE, 16'd5);
        write_reg(CFG_OUT_CAP, 16'd256);
        send_text("  Hi there!");
        send_char(CH_CR);
        send_text(" x  ");
        send_char(CH_LF);
        send_char(CH_END);
    endtask

    // Lowest and highest word codes with a one-column line
    task automatic test_char_extremes();
        wait_block_idle();
        write_reg(CFG_MAX_LINE, 16'd1);
        send_char(8'h01);
        send_char(8'hFF);
        send_char(CH_SP);
        send_char(8'h80);
        send_char(CH_SP);
        send_char(8'h7F);
        send_char(CH_END);
    endtask

    // Truncation at capacity, zero capacity, wrap refused near capacity
    task automatic test_output_full();
        wait_block_idle();
        write_reg(CFG_MAX_LINE, 16'd20);
        write_reg(CFG_OUT_CAP, 16'd6);
        send_text("abc defg");
        send_char(CH_END);
        wait_block_idle();
        write_reg(CFG_OUT_CAP, 16'd0);
        send_text("ab");
        send_char(CH_END);
        wait_block_idle();
        write_reg(CFG_MAX_LINE, 16'd1);
        write_reg(CFG_OUT_CAP, 16'd4);
        send_text("a b");
        send_char(CH_END);
    endtask

    // Words past the store depth, with a line limit above the depth
    task automatic test_long_word();
        wait_block_idle();
        write_reg(CFG_MAX_LINE, 16'd40);
        write_reg(CFG_OUT_CAP, 16'd256);
        send_text("abcdefghij ");
        send_word(WORD_DEPTH + 3);
        send_char(CH_SP);
        send_word(WORD_DEPTH + 1);
        send_char(CH_END);
    endtask

    // Hold the output off long enough for the input to stall
    task automatic test_output_backpressure();
        wait_block_idle();
        write_reg(CFG_MAX_LINE, 16'd12);
        write_reg(CFG_OUT_CAP, 16'hFFFF);
        tx_steady    = 1'b1;
        rx_hold_left = 300;
        for (int w = 0; w < 8; w++) begin
            send_word($urandom_range(2, 7));
            send_char(CH_SP);
        end
        send_char(CH_END);
        tx_steady = 1'b0;
    endtask

    // Mostly well-formed texts with random content, some noise
    task automatic test_random_text();
        int unsigned      start;
        int unsigned      done;
        int unsigned      words;
        int unsigned      pick;
        logic [MAXL_W-1:0] ml;
        logic [9:0]        ml_hi;
        logic [CAP_W-1:0]  cap;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            done      = items_sent - start;
            tx_steady = (done >= 40 && done < 110);
            rx_steady = tx_steady;
            // retune the registers between most texts
            if ($urandom_range(3) != 0) begin
                wait_block_idle();
                case ($urandom_range(7))
                    0:       ml = '0;
                    1:       ml = 6'd1;
                    2:       ml = '1;
                    3:       ml = MAXL_W'(WORD_DEPTH);
                    default: ml = MAXL_W'($urandom_range(2, 40));
                endcase
                case ($urandom_range(9))
                    0:       cap = '0;
                    1:       cap = CAP_W'($urandom_range(1, 6));
                    2:       cap = '1;
                    3:       cap = CAP_W'($urandom_range(7, 60));
                    default: cap = CAP_W'($urandom_range(200, 2000));
                endcase
                ml_hi = 10'($urandom_range(1023));
                write_reg(CFG_MAX_LINE, {ml_hi, ml});
                write_reg(CFG_OUT_CAP, cap);
            end
            if ($urandom_range(3) == 0)
                send_char(CH_SP);
            words = $urandom_range(1, 14);
            for (int w = 0; w < words; w++) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    repeat ($urandom_range(1, 4)) send_char(t_char'($urandom_range(1, 255)));
                end else if (pick < 16) begin
                    send_word($urandom_range(WORD_DEPTH - 4, WORD_DEPTH + 12));
                end else begin
                    send_word($urandom_range(1, 9));
                end
                // word separator
                pick = $urandom_range(99);
                if (pick < 62) begin
                    send_char(CH_SP);
                end else if (pick < 72) begin
                    repeat ($urandom_range(2, 3)) send_char(CH_SP);
                end else if (pick < 80) begin
                    send_char(CH_CR);
                end else if (pick < 88) begin
                    send_char(CH_LF);
                end else if (pick < 94) begin
                    send_char(CH_CR);
                    send_char(CH_LF);
                end else begin
                    send_char(CH_CR);
                    send_char(CH_SP);
                end
            end
            send_char(CH_END);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Run limit
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("** word_boundary_text_wrapper: FAILED **");
        $finish;
    end

    // Test sequence
    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_MAX_LINE;
        i_cfg_wdata    <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.in_char  <= CH_END;
        items_sent     = 0;
        mismatch_count = 0;
        rx_hold_left   = 0;
        rx_steady      = 1'b0;
        tx_steady      = 1'b0;
        max_line       = MAXL_RESET;
        out_cap        = CAP_RESET;
        clear_text_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_wrap_and_spaces();
        test_char_extremes();
        test_output_full();
        test_long_word();
        test_output_backpressure();
        test_random_text();

        wait_block_idle();
        if (wrapped_text_q.size() != 0)
            report_mismatch($sformatf("%0d expected items never arrived",
                                      wrapped_text_q.size()));
        if (mismatch_count == 0) begin
            $display("** word_boundary_text_wrapper: PASSED **");
        end else begin
            $display("** word_boundary_text_wrapper: FAILED **");
        end
        $finish;
    end

endmodule
